FILE: rtl/core/line_raster_with_depth_unit_macros.svh
// Assertion helpers for the top-level file that checks this block.
// Both sample on the rising edge of clk and stay quiet while rst is high.
`ifndef LINE_RASTER_WITH_DEPTH_UNIT_MACROS_SVH
`define LINE_RASTER_WITH_DEPTH_UNIT_MACROS_SVH

// Same-cycle implication.
`define LRD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication.
`define LRD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/core/lrd_pkg.sv
`default_nettype none

package lrd_pkg;

  localparam int COORD_BITS   = 12;
  localparam int SPAN_BITS    = COORD_BITS + 1;
  localparam int INC_BITS     = COORD_BITS + 2;
  localparam int DEC_BITS     = COORD_BITS + 4;
  localparam int DEPTH_BITS   = 32;
  localparam int DIFF_BITS    = DEPTH_BITS + 1;
  localparam int COLOR_BITS   = 24;
  localparam int DIV_CNT_BITS = $clog2(DIFF_BITS);

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  typedef enum logic [1:0] {
    OCT_SHALLOW_UP = 2'd0,
    OCT_SHALLOW_DN = 2'd1,
    OCT_STEEP_UP   = 2'd2,
    OCT_STEEP_DN   = 2'd3
  } lrd_oct_t;

  typedef struct packed {
    logic load;
    logic step;
  } lrd_cmd_t;

  typedef struct packed {
    logic active;
    logic div_done;
  } lrd_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/lrd_in_if.sv
`default_nettype none

interface lrd_in_if
  import lrd_pkg::*;
;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic signed [COORD_BITS-1:0]  start_x;
  logic signed [COORD_BITS-1:0]  start_y;
  logic signed [DEPTH_BITS-1:0]  start_depth;
  logic signed [COORD_BITS-1:0]  end_x;
  logic signed [COORD_BITS-1:0]  end_y;
  logic signed [DEPTH_BITS-1:0]  end_depth;
  logic        [COLOR_BITS-1:0]  line_color;

  modport source (
    output valid, mode, start_x, start_y, start_depth, end_x, end_y, end_depth,
           line_color,
    input  ready
  );

  modport sink (
    input  valid, mode, start_x, start_y, start_depth, end_x, end_y, end_depth,
           line_color,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/lrd_out_if.sv
`default_nettype none

interface lrd_out_if
  import lrd_pkg::*;
;
  logic                          valid;
  logic                          ready;
  logic signed [COORD_BITS-1:0]  pixel_x;
  logic signed [COORD_BITS-1:0]  pixel_y;
  logic signed [DEPTH_BITS-1:0]  pixel_depth;
  logic        [COLOR_BITS-1:0]  pixel_color;
  logic                          last_pixel;

  modport source (
    output valid, pixel_x, pixel_y, pixel_depth, pixel_color, last_pixel,
    input  ready
  );

  modport sink (
    input  valid, pixel_x, pixel_y, pixel_depth, pixel_color, last_pixel,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/line_raster_with_depth_unit.sv
// Channel  Dir  Words
// in_ch    in   mode 0 loads a line (two endpoints, depths, color); mode 1 asks for a pixel
// out_ch   out  pixel x, y, depth (Q15.16), color and last-pixel flag
//
// Pixel steps stream at one word per cycle while the
// output register drains each cycle.
// A load is accepted, then the bit-serial depth-slope divider runs (one quotient
// bit per cycle), and the block returns to taking input once it is done.
// Reset (rst, synchronous) drops any line in flight and empties the output.
// A stalled output holds its word and blocks new input words; a step with
// no active line is taken and dropped.
`default_nettype none

`include "line_raster_with_depth_unit_macros.svh"

module line_raster_with_depth_unit
  import lrd_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  lrd_in_if.sink   in_ch,
  lrd_out_if.source out_ch
);

  lrd_cmd_t  cmd;
  lrd_stat_t stat;

  logic signed [DIFF_BITS-1:0]  div_dividend;
  logic        [SPAN_BITS-1:0]  div_divisor;
  logic        [DEPTH_BITS-1:0] div_quotient;
  logic                         div_done;
  logic                         line_active;
  logic                         in_fire;

  assign in_fire = in_ch.valid && in_ch.ready;

  // gather the status bits the sequencer watches
  assign stat = '{active: line_active, div_done: div_done};

  // sequencer: input handshake, output valid, load/divide/run state
  lrd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_mode   (in_ch.mode),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  // line setup, Bresenham stepping, depth accumulation, output register
  lrd_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .start_x      (in_ch.start_x),
    .start_y      (in_ch.start_y),
    .start_depth  (in_ch.start_depth),
    .end_x        (in_ch.end_x),
    .end_y        (in_ch.end_y),
    .end_depth    (in_ch.end_depth),
    .line_color   (in_ch.line_color),
    .div_done     (div_done),
    .div_quotient (div_quotient),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .active       (line_active),
    .pixel_x      (out_ch.pixel_x),
    .pixel_y      (out_ch.pixel_y),
    .pixel_depth  (out_ch.pixel_depth),
    .pixel_color  (out_ch.pixel_color),
    .last_pixel   (out_ch.last_pixel)
  );

  // depth step = (z1 - z0) / (span + 1), started with the load word
  lrd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.load),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // a load holds off input while the slope divide runs
  `LRD_ASSERT_NEXT(a_load_blocks_input, in_fire && (in_ch.mode == MODE_LOAD), !in_ch.ready)
  // the divider finishes only while input is held off
  `LRD_ASSERT_IMPL(a_done_while_busy, div_done, !in_ch.ready)
  // a step on an active line always yields an output word
  `LRD_ASSERT_NEXT(a_step_emits, cmd.step, out_ch.valid)
  // no new word enters while a result still waits
  `LRD_ASSERT_IMPL(a_no_overrun, out_ch.valid && !out_ch.ready, !in_fire)

endmodule

`default_nettype wire

FILE: rtl/core/lrd_div.sv
`default_nettype none

// Restoring signed divide, one quotient bit per cycle, truncating toward zero.
module lrd_div
  import lrd_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic signed [DIFF_BITS-1:0]  dividend,
  input  wire logic        [SPAN_BITS-1:0]  divisor,
  output logic                              done,
  output logic             [DEPTH_BITS-1:0] quotient
);

  logic                    busy;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic [DIFF_BITS-1:0]    q;
  logic [SPAN_BITS-1:0]    rem;
  logic [SPAN_BITS-1:0]    dvs;
  logic                    neg;

  logic [SPAN_BITS:0]      shifted;
  logic [SPAN_BITS:0]      trial;
  logic [DIFF_BITS-1:0]    q_signed;

  assign shifted  = {rem, q[DIFF_BITS-1]};
  assign trial    = shifted - {1'b0, dvs};
  assign q_signed = neg ? (~q + DIFF_BITS'(1)) : q;
  assign quotient = q_signed[DEPTH_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DIV_CNT_BITS'(1);
        if (cnt == DIV_CNT_BITS'(DIFF_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[DIFF_BITS-1];
      q   <= dividend[DIFF_BITS-1] ? $unsigned(-dividend) : $unsigned(dividend);
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      // keep the trial remainder when it did not go negative
      if (!trial[SPAN_BITS]) begin
        rem <= trial[SPAN_BITS-1:0];
        q   <= {q[DIFF_BITS-2:0], 1'b1};
      end else begin
        rem <= shifted[SPAN_BITS-1:0];
        q   <= {q[DIFF_BITS-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/lrd_ctrl.sv
`default_nettype none

module lrd_ctrl
  import lrd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire logic      in_mode,
  input  wire logic      out_ready,
  input  wire lrd_stat_t stat,
  output logic           in_ready,
  output logic           out_valid,
  output lrd_cmd_t       cmd
);

  typedef enum logic [1:0] {
    ST_RUN = 2'b01,
    ST_DIV = 2'b10
  } lrd_state_t;

  lrd_state_t state, state_next;
  logic       in_fire;

  // take a word only in the run state, when the output register is free or draining
  assign in_ready = (state == ST_RUN) && (!out_valid || out_ready);
  assign in_fire  = in_valid && in_ready;
  assign cmd.load = in_fire && (in_mode == MODE_LOAD);
  assign cmd.step = in_fire && (in_mode == MODE_STEP) && stat.active;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_RUN: if (cmd.load) state_next = ST_DIV;
      ST_DIV: if (stat.div_done) state_next = ST_RUN;
      default: state_next = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/lrd_datapath.sv
`default_nettype none

module lrd_datapath
  import lrd_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire lrd_cmd_t                     cmd,
  input  wire logic signed [COORD_BITS-1:0] start_x,
  input  wire logic signed [COORD_BITS-1:0] start_y,
  input  wire logic signed [DEPTH_BITS-1:0] start_depth,
  input  wire logic signed [COORD_BITS-1:0] end_x,
  input  wire logic signed [COORD_BITS-1:0] end_y,
  input  wire logic signed [DEPTH_BITS-1:0] end_depth,
  input  wire logic        [COLOR_BITS-1:0] line_color,
  input  wire logic                         div_done,
  input  wire logic        [DEPTH_BITS-1:0] div_quotient,
  output logic signed      [DIFF_BITS-1:0]  div_dividend,
  output logic             [SPAN_BITS-1:0]  div_divisor,
  output logic                              active,
  output logic signed      [COORD_BITS-1:0] pixel_x,
  output logic signed      [COORD_BITS-1:0] pixel_y,
  output logic signed      [DEPTH_BITS-1:0] pixel_depth,
  output logic             [COLOR_BITS-1:0] pixel_color,
  output logic                              last_pixel
);

  // line state
  lrd_oct_t                 octant;
  logic signed [COORD_BITS-1:0] cur_x, cur_y, stop_coord;
  logic signed [DEC_BITS-1:0]   decision;
  logic signed [INC_BITS-1:0]   inc_a, inc_b;
  logic        [DEPTH_BITS-1:0] depth_acc, depth_step;
  logic        [COLOR_BITS-1:0] held_color;

  // load setup
  logic                         swap;
  logic signed [COORD_BITS-1:0] x0, y0, x1, y1;
  logic signed [DEPTH_BITS-1:0] z0, z1;
  logic signed [SPAN_BITS-1:0]  dx, dy, ady, span;
  logic signed [DEC_BITS-1:0]   dx_d, dy_d, d_init;
  logic signed [INC_BITS-1:0]   a_init, b_init;
  logic                         shallow, rising;
  lrd_oct_t                     oct_init;

  // step
  logic signed [DEC_BITS-1:0]   a_ext, b_ext, d_next;
  logic signed [COORD_BITS-1:0] x_next, y_next, major;
  logic                         last;

  assign swap = end_x < start_x;
  assign x0   = swap ? end_x : start_x;
  assign y0   = swap ? end_y : start_y;
  assign z0   = swap ? end_depth : start_depth;
  assign x1   = swap ? start_x : end_x;
  assign y1   = swap ? start_y : end_y;
  assign z1   = swap ? start_depth : end_depth;

  assign dx      = SPAN_BITS'(x1) - SPAN_BITS'(x0);
  assign dy      = SPAN_BITS'(y1) - SPAN_BITS'(y0);
  assign ady     = dy[SPAN_BITS-1] ? -dy : dy;
  assign shallow = dx >= ady;
  assign rising  = !dy[SPAN_BITS-1];
  assign dx_d    = DEC_BITS'(dx);
  assign dy_d    = DEC_BITS'(dy);
  assign a_init  = signed'({dy, 1'b0});
  assign b_init  = -signed'({dx, 1'b0});

  always_comb begin
    if (shallow) begin
      span     = dx;
      oct_init = rising ? OCT_SHALLOW_UP : OCT_SHALLOW_DN;
      d_init   = rising ? ((dy_d <<< 1) - dx_d) : ((dy_d <<< 1) + dx_d);
    end else begin
      span     = rising ? dy : -dy;
      oct_init = rising ? OCT_STEEP_UP : OCT_STEEP_DN;
      d_init   = rising ? (dy_d - (dx_d <<< 1)) : ((dx_d <<< 1) - dy_d);
    end
  end

  assign div_divisor  = $unsigned(span) + SPAN_BITS'(1);
  assign div_dividend = DIFF_BITS'(z1) - DIFF_BITS'(z0);

  assign a_ext = DEC_BITS'(inc_a);
  assign b_ext = DEC_BITS'(inc_b);
  assign major = (octant == OCT_SHALLOW_UP || octant == OCT_SHALLOW_DN) ? cur_x : cur_y;
  assign last  = major == stop_coord;

  always_comb begin
    x_next = cur_x;
    y_next = cur_y;
    d_next = decision;
    case (octant)
      OCT_SHALLOW_UP: begin
        if (decision > 0) begin
          y_next = cur_y + COORD_BITS'(1);
          d_next = decision + a_ext + b_ext;
        end else begin
          d_next = decision + a_ext;
        end
        x_next = cur_x + COORD_BITS'(1);
      end
      OCT_SHALLOW_DN: begin
        if (decision < 0) begin
          y_next = cur_y - COORD_BITS'(1);
          d_next = decision + a_ext - b_ext;
        end else begin
          d_next = decision + a_ext;
        end
        x_next = cur_x + COORD_BITS'(1);
      end
      OCT_STEEP_UP: begin
        if (decision < 0) begin
          x_next = cur_x + COORD_BITS'(1);
          d_next = decision + a_ext + b_ext;
        end else begin
          d_next = decision + b_ext;
        end
        y_next = cur_y + COORD_BITS'(1);
      end
      default: begin
        if (decision > 0) begin
          x_next = cur_x + COORD_BITS'(1);
          d_next = decision + a_ext - b_ext;
        end else begin
          d_next = decision - b_ext;
        end
        y_next = cur_y - COORD_BITS'(1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (cmd.load) begin
      active <= 1'b1;
    end else if (cmd.step && last) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      octant     <= oct_init;
      cur_x      <= x0;
      cur_y      <= y0;
      stop_coord <= shallow ? x1 : y1;
      decision   <= d_init;
      inc_a      <= a_init;
      inc_b      <= b_init;
      depth_acc  <= $unsigned(z0);
      held_color <= line_color;
    end else if (cmd.step) begin
      cur_x     <= x_next;
      cur_y     <= y_next;
      decision  <= d_next;
      depth_acc <= depth_acc + depth_step;
    end
    if (div_done) begin
      depth_step <= div_quotient;
    end
  end

  // output register, loaded with the pixel before the advance
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      pixel_x     <= cur_x;
      pixel_y     <= cur_y;
      pixel_depth <= signed'(depth_acc);
      pixel_color <= held_color;
      last_pixel  <= last;
    end
  end

endmodule

`default_nettype wire
